### sv/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int POS_W       = $clog2(BLOCK_BYTES);
   localparam int BLK_WORDS   = BLOCK_BYTES / 4;
   localparam int COUNT_W     = 61;
   localparam int LEN_W       = 64;
   localparam int ROUNDS      = 80;
   localparam int RND_W       = 7;
   localparam int DIG_WORDS   = 5;
   localparam int IDX_W       = 3;

   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(BLOCK_BYTES - 8);
   localparam logic [RND_W-1:0] RND_LAST   = RND_W'(ROUNDS - 1);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(DIG_WORDS - 1);

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] INIT_H [DIG_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0]      digest_word;
      logic [IDX_W-1:0] word_index;
      logic             last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         wr_byte;
      byte_src_type src;
      logic         cnt_inc;
      logic         len_load;
      logic         comp_start;
      logic         round_step;
      logic         chain_add;
      logic         out_next;
      logic         reinit;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_len;
      logic round_last;
      logic out_last;
   } dp_stat_type;

   function automatic logic [31:0] sha1md_k(input logic [RND_W-1:0] rnd);
      logic [31:0] k;
      if (rnd < RND_W'(20)) begin
         k = 32'h5A82_7999;
      end else if (rnd < RND_W'(40)) begin
         k = 32'h6ED9_EBA1;
      end else if (rnd < RND_W'(60)) begin
         k = 32'h8F1B_BCDC;
      end else begin
         k = 32'hCA62_C1D6;
      end
      return k;
   endfunction

   function automatic logic [31:0] sha1md_f(input logic [RND_W-1:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      logic [31:0] f;
      if (rnd < RND_W'(20)) begin
         f = d ^ (b & (c ^ d));
      end else if (rnd >= RND_W'(40) && rnd < RND_W'(60)) begin
         f = (b & c) | (d & (b | c));
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

### sv/sha1md_ctrl.sv
// Controller state machine: byte intake, padding sequence, compression and digest output.
`default_nettype none

module sha1md_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sha1md_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sha1md_pkg::dp_cmd_type    cmd,
   input  wire sha1md_pkg::dp_stat_type stat
);
   import sha1md_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      cmd.src   = SRC_DATA;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.len_load = req_data.message_end;
               if (req_data.byte_valid) begin
                  cmd.wr_byte = 1'b1;
                  cmd.cnt_inc = 1'b1;
               end
               if (req_data.byte_valid && stat.pos_last) begin
                  // The byte completes a block: compress before anything else.
                  cmd.comp_start = 1'b1;
                  state_in       = ST_ROUND;
                  ret_in         = req_data.message_end ? ST_MARK : ST_IDLE;
               end else if (req_data.message_end) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            cmd.wr_byte = 1'b1;
            cmd.src     = SRC_MARK;
            if (stat.pos_last) begin
               cmd.comp_start = 1'b1;
               ret_in         = ST_ZERO;
               state_in       = ST_ROUND;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (stat.pos_len) begin
               state_in = ST_LEN;
            end else begin
               cmd.wr_byte = 1'b1;
               cmd.src     = SRC_ZERO;
               if (stat.pos_last) begin
                  cmd.comp_start = 1'b1;
                  ret_in         = ST_ZERO;
                  state_in       = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            cmd.wr_byte = 1'b1;
            cmd.src     = SRC_LEN;
            if (stat.pos_last) begin
               cmd.comp_start = 1'b1;
               ret_in         = ST_OUT;
               state_in       = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (stat.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (stat.out_last) begin
                  cmd.reinit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The chain update always follows the last round directly.
   a_add_after_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(state_ff) == ST_ROUND)
      else $error("chain update without preceding rounds");

   a_rounds_continue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && !stat.round_last) |=> state_ff == ST_ROUND)
      else $error("compression left before the last round");

   a_no_write_in_round: assert property (@(posedge clock) disable iff (reset)
      cmd.round_step |-> !cmd.wr_byte && !req_ready)
      else $error("block write or intake during compression");

   a_output_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready && !cmd.wr_byte)
      else $error("digest output overlaps message intake");

endmodule

`default_nettype wire

### sv/sha1md_dp.sv
// Datapath: block buffer and schedule window, round logic, chain values, counters.
`default_nettype none

module sha1md_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sha1md_pkg::dp_cmd_type cmd,
   input  wire logic [7:0]             req_byte,
   output sha1md_pkg::dp_stat_type     stat,
   output sha1md_pkg::rsp_type         rsp_data
);
   import sha1md_pkg::*;

   logic [31:0]        block_ff [BLK_WORDS];
   logic [31:0]        block_in [BLK_WORDS];
   logic [31:0]        work_ff  [DIG_WORDS];
   logic [31:0]        work_in  [DIG_WORDS];
   logic [31:0]        chain_ff [DIG_WORDS];
   logic [31:0]        chain_in [DIG_WORDS];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic [7:0]  byte_val;
   logic [4:0]  lane_sh;
   logic [31:0] sched_x;
   logic [31:0] sched_word;
   logic [31:0] round_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         chain_ff <= INIT_H;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
      len_ff   <= len_in;
   end

   always_comb begin
      case (cmd.src)
         SRC_DATA: byte_val = req_byte;
         SRC_MARK: byte_val = PAD_MARK;
         SRC_ZERO: byte_val = 8'h00;
         SRC_LEN:  byte_val = len_ff[LEN_W-1 -: 8];
         default:  byte_val = 8'h00;
      endcase
   end

   // Big-endian packing: byte lane 0 lands in the top bits of its word.
   assign lane_sh    = {~pos_ff[1:0], 3'b000};
   assign sched_x    = block_ff[13] ^ block_ff[8] ^ block_ff[2] ^ block_ff[0];
   assign sched_word = {sched_x[30:0], sched_x[31]};
   assign round_sum  = {work_ff[0][26:0], work_ff[0][31:27]}
                     + sha1md_f(rnd_ff, work_ff[1], work_ff[2], work_ff[3])
                     + work_ff[4] + sha1md_k(rnd_ff) + block_ff[0];

   always_comb begin
      block_in = block_ff;
      if (cmd.round_step) begin
         // The buffer doubles as the sixteen-word schedule window.
         for (int i = 0; i < BLK_WORDS - 1; i++) begin
            block_in[i] = block_ff[i+1];
         end
         block_in[BLK_WORDS-1] = sched_word;
      end else if (cmd.wr_byte) begin
         block_in[pos_ff[POS_W-1:2]][lane_sh +: 8] = byte_val;
      end
   end

   always_comb begin
      work_in = work_ff;
      rnd_in  = rnd_ff;
      if (cmd.comp_start) begin
         work_in = chain_ff;
         rnd_in  = '0;
      end else if (cmd.round_step) begin
         work_in[0] = round_sum;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
         rnd_in     = rnd_ff + RND_W'(1);
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.reinit) begin
         chain_in = INIT_H;
      end else if (cmd.chain_add) begin
         for (int i = 0; i < DIG_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      if (cmd.reinit) begin
         pos_in   = '0;
         count_in = '0;
         idx_in   = '0;
      end else begin
         if (cmd.wr_byte) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (cmd.cnt_inc) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (cmd.out_next) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      if (cmd.len_load) begin
         len_in = {count_in, 3'b000};
      end else if (cmd.wr_byte && cmd.src == SRC_LEN) begin
         len_in = {len_ff[LEN_W-9:0], 8'h00};
      end
   end

   assign stat.pos_last   = (pos_ff == POS_LAST);
   assign stat.pos_len    = (pos_ff == POS_LENGTH);
   assign stat.round_last = (rnd_ff == RND_LAST);
   assign stat.out_last   = (idx_ff == IDX_LAST);

   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = stat.out_last;

   a_compress_full_block: assert property (@(posedge clock) disable iff (reset)
      cmd.comp_start |-> cmd.wr_byte && pos_ff == POS_LAST)
      else $error("compression started on a partial block");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.round_step && !stat.round_last) |=> rnd_ff == $past(rnd_ff) + RND_W'(1))
      else $error("round counter skipped");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_LAST)
      else $error("digest word index out of range");

endmodule

`default_nettype wire

### sv/sha1_message_digest.sv
// Top level of the SHA-1 message digest block: controller and datapath.
//
// The req channel carries one transaction per message byte (data_byte with
// byte_valid) and/or a message_end flag. Bytes are taken one per cycle while
// the block is idle. Every 64th byte starts a compression: 80 rounds at one
// round per cycle in the single shared round unit, then the chain update;
// no byte is taken until it is done. A transaction with message_end starts
// the padding sequence, which writes one pad or length byte per cycle while
// no block is compressed (9 to 72 bytes, with one step that writes nothing
// before the length field). It also compresses one or two more blocks, each
// with its rounds and chain update. The digest then leaves on the rsp
// channel as five transactions, word 0 first, last_word set on word 4.
// While the receiver stalls, the current word holds and no new req
// transaction is taken. After the fifth word the chain values and the byte
// count go back to their initial values for the next message.
// Reset is synchronous; it clears the controller, the counters and the chain
// values, and the block is ready for a byte as soon as it is released.
`default_nettype none

module sha1_message_digest (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sha1md_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sha1md_pkg::rsp_type      rsp_data
);
   import sha1md_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sha1md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sha1md_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_byte (req_data.data_byte),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
